### rtl/mmc3_pkg.sv
`default_nettype none

package mmc3_pkg;

	// input item: cpu register write or scanline tick
	typedef struct packed {
		logic        command;
		logic [15:0] addr;
		logic [7:0]  value;
	} in_item_t;

	// result item: prg mapping, mirroring and irq line
	typedef struct packed {
		logic [7:0] prg_bank0;
		logic [7:0] prg_bank1;
		logic [7:0] prg_bank2;
		logic [7:0] prg_bank3;
		logic       mirror_horizontal;
		logic       irq_out;
	} out_item_t;

	// item kinds
	localparam logic CMD_CPU_WRITE = 1'b0;
	localparam logic CMD_SCANLINE  = 1'b1;

	// register decode on {addr[15], addr[14], addr[13], addr[0]}
	typedef enum logic [3:0] {
		REG_BANK_SELECT = 4'b1000,
		REG_BANK_DATA   = 4'b1001,
		REG_MIRROR      = 4'b1010,
		REG_PRG_RAM     = 4'b1011,
		REG_IRQ_LATCH   = 4'b1100,
		REG_IRQ_RELOAD  = 4'b1101,
		REG_IRQ_DISABLE = 4'b1110,
		REG_IRQ_ENABLE  = 4'b1111
	} reg_sel_t;

	localparam int unsigned NUM_BANK_REGS = 8;
	localparam int unsigned PRG_MODE_BIT  = 6;
	localparam logic [8:0]  BANK_COUNT_RESET = 9'd2;

	typedef logic [7:0] bank_arr_t [NUM_BANK_REGS];
	localparam bank_arr_t BANK_RESET = '{8'd0, 8'd2, 8'd4, 8'd5, 8'd6, 8'd7, 8'd0, 8'd1};

	// modulo unit retires two dividend bits per cycle over an 8-bit bank number
	localparam int unsigned BITS_PER_STEP = 2;
	localparam int unsigned MOD_STEPS     = 8 / BITS_PER_STEP;
	localparam logic [1:0]  STEP_LAST     = 2'(MOD_STEPS - 1);

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_DONE
	} ctl_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic apply;     // apply the accepted item to mapper state
		logic step;      // one modulo iteration
		logic first;     // first iteration, dividends come from the bank registers
		logic load_out;  // capture the result beat
	} dp_cmd_t;

endpackage

`default_nettype wire

### rtl/mmc3_ctrl.sv
`default_nettype none

module mmc3_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output mmc3_pkg::dp_cmd_t     cmd
);
	import mmc3_pkg::*;

	ctl_state_t state_q, state_d;
	logic [1:0] step_q;
	logic       out_valid_q;
	logic       out_room;

	// output register is free or being emptied this cycle
	assign out_room = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_CALC;
			end
			ST_CALC: begin
				if (step_q == STEP_LAST) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_room) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs toward datapath and handshake
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall  = 1'b0;
				cmd.apply = in_valid;
			end
			ST_CALC: begin
				cmd.step  = 1'b1;
				cmd.first = (step_q == '0);
			end
			ST_DONE: begin
				cmd.load_out = out_room;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	// state, iteration count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.step) step_q <= step_q + 2'd1;
			else          step_q <= '0;
			if (cmd.load_out)    out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

### rtl/mmc3_dpath.sv
`default_nettype none

module mmc3_dpath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mmc3_pkg::dp_cmd_t cmd,
	input  wire mmc3_pkg::in_item_t in_data,
	input  wire logic              cfg_we,
	input  wire logic [8:0]        cfg_data,
	output mmc3_pkg::out_item_t    out_data
);
	import mmc3_pkg::*;

	// one restoring remainder step: shift in a bit, subtract count if it fits
	function automatic logic [8:0] mod_step(input logic [8:0] r, input logic b,
		input logic [8:0] cnt);
		logic [9:0] t;
		t = {r, b};
		if (t >= {1'b0, cnt}) t = t - {1'b0, cnt};
		return t[8:0];
	endfunction

	logic [8:0] bank_count_q;
	logic [7:0] bank_select_q;
	logic [7:0] bank_q [NUM_BANK_REGS];
	logic [7:0] irq_latch_q;
	logic [7:0] irq_count_q;
	logic       reload_q;
	logic       irq_en_q;
	logic       irq_q;
	logic       mirror_q;

	logic [7:0] div6_q, div7_q;
	logic [8:0] rem6_q, rem7_q;
	out_item_t  out_q;

	reg_sel_t   sel;
	logic [7:0] count_next;
	logic       count_take_latch;

	logic [7:0] src6, src7;
	logic [8:0] r6_in, r7_in, r6_mid, r7_mid, r6_out, r7_out;

	logic [7:0] last_bank, second_bank;
	out_item_t  res;

	assign sel = reg_sel_t'({in_data.addr[15], in_data.addr[14], in_data.addr[13],
		in_data.addr[0]});

	// scanline counter: reload from latch or decrement
	assign count_take_latch = (irq_count_q == '0) || reload_q;
	assign count_next       = count_take_latch ? irq_latch_q : irq_count_q - 8'd1;

	// mapper register file and irq counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_count_q  <= BANK_COUNT_RESET;
			bank_select_q <= '0;
			for (int i = 0; i < NUM_BANK_REGS; i++) bank_q[i] <= BANK_RESET[i];
			irq_latch_q   <= '0;
			irq_count_q   <= '0;
			reload_q      <= 1'b0;
			irq_en_q      <= 1'b0;
			irq_q         <= 1'b0;
			mirror_q      <= 1'b0;
		end else begin
			if (cfg_we) bank_count_q <= cfg_data;
			if (cmd.apply) begin
				if (in_data.command == CMD_SCANLINE) begin
					irq_count_q <= count_next;
					if (count_take_latch) reload_q <= 1'b0;
					if ((count_next == '0) && irq_en_q) irq_q <= 1'b1;
				end else if (in_data.addr[15]) begin
					unique case (sel)
						REG_BANK_SELECT: bank_select_q <= in_data.value;
						REG_BANK_DATA:   bank_q[bank_select_q[2:0]] <= in_data.value;
						REG_MIRROR:      mirror_q <= in_data.value[0];
						REG_IRQ_LATCH:   irq_latch_q <= in_data.value;
						REG_IRQ_RELOAD: begin
							irq_count_q <= '0;
							reload_q    <= 1'b1;
						end
						REG_IRQ_DISABLE: begin
							irq_en_q <= 1'b0;
							irq_q    <= 1'b0;
						end
						REG_IRQ_ENABLE:  irq_en_q <= 1'b1;
						default: ;
					endcase
				end
			end
		end
	end

	// modulo unit: banks 6 and 7 in parallel, two bits per cycle
	assign src6   = cmd.first ? bank_q[6] : div6_q;
	assign src7   = cmd.first ? bank_q[7] : div7_q;
	assign r6_in  = cmd.first ? '0 : rem6_q;
	assign r7_in  = cmd.first ? '0 : rem7_q;
	assign r6_mid = mod_step(r6_in, src6[7], bank_count_q);
	assign r7_mid = mod_step(r7_in, src7[7], bank_count_q);
	assign r6_out = mod_step(r6_mid, src6[6], bank_count_q);
	assign r7_out = mod_step(r7_mid, src7[6], bank_count_q);

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			div6_q <= {src6[5:0], 2'b00};
			div7_q <= {src7[5:0], 2'b00};
			rem6_q <= r6_out;
			rem7_q <= r7_out;
		end
	end

	// fixed banks from the bank count
	always_comb begin
		if (bank_count_q == '0) begin
			last_bank   = 8'hFF;
			second_bank = 8'hFE;
		end else begin
			last_bank   = 8'(bank_count_q - 9'd1);
			second_bank = (bank_count_q >= 9'd2) ? 8'(bank_count_q - 9'd2) : 8'd0;
		end
	end

	// result assembly by prg mode
	always_comb begin
		res.prg_bank1         = rem7_q[7:0];
		res.prg_bank3         = last_bank;
		res.mirror_horizontal = mirror_q;
		res.irq_out           = irq_q;
		if (bank_select_q[PRG_MODE_BIT]) begin
			res.prg_bank0 = second_bank;
			res.prg_bank2 = rem6_q[7:0];
		end else begin
			res.prg_bank0 = rem6_q[7:0];
			res.prg_bank2 = second_bank;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) out_q <= res;
	end

	assign out_data = out_q;

endmodule

`default_nettype wire

### rtl/mmc3_prg_bank_and_scanline_irq_unit.sv
`default_nettype none

// MMC3 PRG banking and scanline IRQ. Each input beat is either a CPU register
// write (decoded on address bits 15, 14, 13 and 0) or a scanline tick that
// clocks the IRQ counter; every beat yields one result beat with the four 8 KiB
// PRG bank numbers, the mirroring bit and the IRQ flag. The accepting edge
// updates the mapper registers, the calc state then runs two remainder units
// in parallel that reduce banks 6 and 7 modulo the bank count two bits per
// cycle, and the done state loads the output register once it has room. The
// next input beat can be taken after that, so an item waits in the done state
// while the result side stalls. A new item is taken while a finished result
// still waits in the output register. The bank count is written through the
// cfg port, which is always ready; write it only while no item is in flight.
module mmc3_prg_bank_and_scanline_irq_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire mmc3_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output mmc3_pkg::out_item_t      out_data,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [8:0]          cfg_data
);
	import mmc3_pkg::*;

	dp_cmd_t cmd;

	assign cfg_ready = 1'b1;

	mmc3_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	mmc3_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_data (cfg_data),
		.out_data (out_data)
	);

endmodule

`default_nettype wire

### tb/mmc3_prg_bank_and_scanline_irq_unit_checker.sv
`timescale 1ns / 100ps

module mmc3_prg_bank_and_scanline_irq_unit_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  mmc3_pkg::in_item_t  in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  mmc3_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [8:0]          cfg_data,
	output int                  fail_count,
	output int                  results_owed,
	output int                  items_seen,
	output int                  results_seen,
	output int                  irq_results
);
	import mmc3_pkg::*;

	// shadow copy of the mapper registers
	logic [8:0] bank_count;
	logic [7:0] select_q;
	logic [7:0] banks [NUM_BANK_REGS];
	logic [7:0] latch_q;
	logic [7:0] count_q;
	logic       reload_q;
	logic       irq_en_q;
	logic       irq_q;
	logic       mirror_q;

	// predicted result beats, oldest first
	out_item_t  bank_views_q [$];

	int errors;
	int n_items;
	int n_results;
	int n_irq;

	task automatic report_mismatch(string field, int got, int want);
		// keep the log short on a broken build, the count still grows
		if (errors < 40)
			$display("[%0t] result %0d %s: got %0h, want %0h", $time, n_results, field,
				got, want);
		errors++;
	endtask

	function automatic void mapper_reset();
		bank_count = BANK_COUNT_RESET;
		select_q   = '0;
		for (int k = 0; k < NUM_BANK_REGS; k++)
			banks[k] = BANK_RESET[k];
		latch_q    = '0;
		count_q    = '0;
		reload_q   = 1'b0;
		irq_en_q   = 1'b0;
		irq_q      = 1'b0;
		mirror_q   = 1'b0;
	endfunction

	// bank number modulo the bank count, a zero count passes it through
	function automatic logic [7:0] wrap_bank(logic [7:0] n);
		if (bank_count == 9'd0)
			return n;
		return 8'({1'b0, n} % bank_count);
	endfunction

	// register write or scanline tick
	function automatic void mapper_apply(in_item_t it);
		reg_sel_t sel;
		sel = reg_sel_t'({it.addr[15:13], it.addr[0]});
		if (it.command == CMD_CPU_WRITE) begin
			if (it.addr[15]) begin
				case (sel)
					REG_BANK_SELECT: select_q = it.value;
					REG_BANK_DATA:   banks[select_q[2:0]] = it.value;
					REG_MIRROR:      mirror_q = it.value[0];
					REG_PRG_RAM:     ;
					REG_IRQ_LATCH:   latch_q = it.value;
					REG_IRQ_RELOAD: begin
						count_q  = '0;
						reload_q = 1'b1;
					end
					REG_IRQ_DISABLE: begin
						irq_en_q = 1'b0;
						irq_q    = 1'b0;
					end
					REG_IRQ_ENABLE:  irq_en_q = 1'b1;
					default:         ;
				endcase
			end
		end else begin
			if (count_q == 8'd0 || reload_q) begin
				count_q  = latch_q;
				reload_q = 1'b0;
			end else begin
				count_q = count_q - 8'd1;
			end
			if (count_q == 8'd0 && irq_en_q)
				irq_q = 1'b1;
		end
	endfunction

	// prg window mapping, mirroring and irq as seen after the update
	function automatic out_item_t mapper_view();
		out_item_t  r;
		logic [7:0] b6;
		logic [7:0] b7;
		logic [7:0] last_bank;
		logic [7:0] second_bank;
		b6 = wrap_bank(banks[6]);
		b7 = wrap_bank(banks[7]);
		if (bank_count == 9'd0) begin
			last_bank   = 8'hFF;
			second_bank = 8'hFE;
		end else begin
			last_bank   = 8'(bank_count - 9'd1);
			second_bank = (bank_count >= 9'd2) ? 8'(bank_count - 9'd2) : 8'h00;
		end
		if (select_q[PRG_MODE_BIT]) begin
			r.prg_bank0 = second_bank;
			r.prg_bank2 = b6;
		end else begin
			r.prg_bank0 = b6;
			r.prg_bank2 = second_bank;
		end
		r.prg_bank1         = b7;
		r.prg_bank3         = last_bank;
		r.mirror_horizontal = mirror_q;
		r.irq_out           = irq_q;
		return r;
	endfunction

	task automatic check_result(out_item_t got);
		out_item_t want;
		n_results++;
		if (got.irq_out)
			n_irq++;
		if (bank_views_q.size() == 0) begin
			report_mismatch("unexpected beat", int'(got), 0);
			return;
		end
		want = bank_views_q.pop_front();
		if (got.prg_bank0 !== want.prg_bank0)
			report_mismatch("prg_bank0", got.prg_bank0, want.prg_bank0);
		if (got.prg_bank1 !== want.prg_bank1)
			report_mismatch("prg_bank1", got.prg_bank1, want.prg_bank1);
		if (got.prg_bank2 !== want.prg_bank2)
			report_mismatch("prg_bank2", got.prg_bank2, want.prg_bank2);
		if (got.prg_bank3 !== want.prg_bank3)
			report_mismatch("prg_bank3", got.prg_bank3, want.prg_bank3);
		if (got.mirror_horizontal !== want.mirror_horizontal)
			report_mismatch("mirror_horizontal", got.mirror_horizontal,
				want.mirror_horizontal);
		if (got.irq_out !== want.irq_out)
			report_mismatch("irq_out", got.irq_out, want.irq_out);
	endtask

	// watch all three channels, result side first
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mapper_reset();
			bank_views_q.delete();
		end else begin
			if (out_valid && !out_stall)
				check_result(out_data);
			if (cfg_valid && cfg_ready)
				bank_count = cfg_data;
			if (in_valid && !in_stall) begin
				mapper_apply(in_data);
				bank_views_q.push_back(mapper_view());
				n_items++;
			end
		end
		fail_count   <= errors;
		results_owed <= bank_views_q.size();
		items_seen   <= n_items;
		results_seen <= n_results;
		irq_results  <= n_irq;
	end

endmodule

### tb/mmc3_prg_bank_and_scanline_irq_unit_test.sv
`timescale 1ns / 100ps

module mmc3_prg_bank_and_scanline_irq_unit_test;
	import mmc3_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam int PHASES     = 9;
	localparam int PER_PHASE  = 214;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	in_item_t   in_data   = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_item_t  out_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [8:0] cfg_data  = '0;

	int fail_count;
	int results_owed;
	int items_seen;
	int results_seen;
	int irq_results;
	int idle_cycles = 0;
	bit hold_req    = 1'b0;
	bit no_gaps     = 1'b0;

	mmc3_prg_bank_and_scanline_irq_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	mmc3_prg_bank_and_scanline_irq_unit_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_data     (out_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.results_owed (results_owed),
		.items_seen   (items_seen),
		.results_seen (results_seen),
		.irq_results  (irq_results)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d results owed", IDLE_LIMIT,
				results_owed);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// result side back-pressure, with one long hold-off on request
	initial begin
		int r;
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (150) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 50) begin
					out_stall <= 1'b0;
					n = $urandom_range(1, 4);
				end else if (r < 80) begin
					out_stall <= 1'b1;
					n = $urandom_range(1, 3);
				end else if (r < 90) begin
					out_stall <= 1'b1;
					n = $urandom_range(8, 30);
				end else begin
					out_stall <= 1'b0;
					n = $urandom_range(30, 80);
				end
				repeat (n) @(posedge clk);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	function automatic in_item_t cpu_write(logic [15:0] addr, logic [7:0] value);
		in_item_t it;
		it.command = CMD_CPU_WRITE;
		it.addr    = addr;
		it.value   = value;
		return it;
	endfunction

	function automatic in_item_t scan_tick(logic [15:0] addr, logic [7:0] value);
		in_item_t it;
		it.command = CMD_SCANLINE;
		it.addr    = addr;
		it.value   = value;
		return it;
	endfunction

	// mostly decoded writes and ticks, small latches so the irq fires often
	function automatic in_item_t random_beat();
		reg_sel_t    sel;
		int          r;
		logic [7:0]  value;
		logic [11:0] mid;
		r     = $urandom_range(0, 99);
		value = 8'($urandom);
		mid   = 12'($urandom);
		if (r < 42)
			return scan_tick(16'($urandom), value);
		if (r < 47)
			return cpu_write({1'b0, 15'($urandom)}, value);
		r = $urandom_range(0, 99);
		if (r < 14)
			sel = REG_BANK_SELECT;
		else if (r < 32)
			sel = REG_BANK_DATA;
		else if (r < 40)
			sel = REG_MIRROR;
		else if (r < 45)
			sel = REG_PRG_RAM;
		else if (r < 60)
			sel = REG_IRQ_LATCH;
		else if (r < 72)
			sel = REG_IRQ_RELOAD;
		else if (r < 80)
			sel = REG_IRQ_DISABLE;
		else
			sel = REG_IRQ_ENABLE;
		if (sel == REG_IRQ_LATCH && $urandom_range(0, 3) != 0)
			value = 8'($urandom_range(0, 6));
		return cpu_write({sel[3:1], mid, sel[0]}, value);
	endfunction

	// hold each beat until accepted, valid stays high across back-to-back beats
	task automatic send_item(in_item_t it);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
	endtask

	task automatic set_bank_count(logic [8:0] n);
		cfg_valid <= 1'b1;
		cfg_data  <= n;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// main stimulus
	initial begin
		logic [8:0] counts [PHASES];
		counts[0] = 9'd0;
		counts[1] = 9'd1;
		counts[2] = 9'd2;
		counts[3] = 9'd255;
		counts[4] = 9'd256;
		counts[5] = 9'd257;
		counts[6] = 9'd511;
		counts[7] = 9'($urandom_range(3, 254));
		counts[8] = 9'($urandom_range(258, 510));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats under the reset bank count
		send_item(cpu_write(16'h0000, 8'hFF));
		send_item(cpu_write(16'h7FFF, 8'hAA));
		send_item(cpu_write(16'h8000, 8'h06));
		send_item(cpu_write(16'h8001, 8'hFF));
		send_item(cpu_write(16'h8000, 8'h47));
		send_item(cpu_write(16'h9FFF, 8'h80));
		send_item(cpu_write(16'hA000, 8'h01));
		send_item(cpu_write(16'hA001, 8'hFF));
		send_item(cpu_write(16'hC000, 8'h02));
		send_item(cpu_write(16'hC001, 8'h00));
		send_item(cpu_write(16'hE001, 8'h00));
		send_item(scan_tick(16'hFFFF, 8'hFF));
		send_item(scan_tick(16'h8001, 8'h55));
		send_item(scan_tick(16'h0000, 8'h00));
		send_item(scan_tick(16'hC001, 8'hAA));
		send_item(cpu_write(16'hE000, 8'h00));
		send_item(cpu_write(16'hDFFE, 8'h00));
		send_item(cpu_write(16'hFFFF, 8'hFF));
		send_item(cpu_write(16'hDFFF, 8'h00));
		send_item(scan_tick(16'h1234, 8'h5A));
		send_item(cpu_write(16'hFFFE, 8'h00));
		send_item(cpu_write(16'hBFFE, 8'hFE));
		send_item(cpu_write(16'h8000, 8'h00));
		send_item(scan_tick(16'h0000, 8'h00));

		// random phases, each under its own bank count
		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			set_bank_count(counts[p]);
			no_gaps = (p == 2 || p == 6);
			for (int i = 0; i < PER_PHASE; i++) begin
				if (p == 3 && i == 30)
					hold_req = 1'b1;
				if (p == 5 && i == 100)
					wait_drained();
				send_item(random_beat());
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		$display("covered %0d items and %0d result beats, %0d of them with irq high",
			items_seen, results_seen, irq_results);
		$display("bank counts 0, 1, 2, 255, 256, 257, 511, %0d and %0d, with back-pressure",
			counts[7], counts[8]);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
